[sv/stepper_ramp_step_generator_core_defines.svh]
// assertion macros shared by the step generator rtl
// no dependencies; included by the files that carry assertions
`ifndef STEPPER_RAMP_STEP_GENERATOR_CORE_DEFINES_SVH
`define STEPPER_RAMP_STEP_GENERATOR_CORE_DEFINES_SVH

// same-cycle implication
`define SRSG_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed in %m");

// next-cycle implication
`define SRSG_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed in %m");

`endif

[sv/srsg_pkg.sv]
// types and constants of the stepper step generator
// no dependencies; used by controller, datapath and top level
package srsg_pkg;

   localparam int NUM_MOTORS = 3;

   localparam int CMD_W    = 1;
   localparam int MOTOR_W  = 2;
   localparam int SPEED_W  = 16;
   localparam int ACCEL_W  = 15;
   localparam int PERIOD_W = 24;
   localparam int FACTOR_W = 8;
   localparam int DIR_W    = 2;
   localparam int POS_W    = 32;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 24;

   // item commands
   localparam logic [CMD_W-1:0] CMD_SET_SPEED = 1'b0;
   localparam logic [CMD_W-1:0] CMD_TICK      = 1'b1;

   // motion direction codes
   localparam logic [DIR_W-1:0] DIR_STOP = 2'd0;
   localparam logic [DIR_W-1:0] DIR_FWD  = 2'd1;
   localparam logic [DIR_W-1:0] DIR_REV  = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ACCEL_CAP    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STOP_PERIOD  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SPEED_FACTOR = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DIR_POLARITY = 2'd3;

   // register reset values
   localparam logic [ACCEL_W-1:0]    RST_ACCEL_CAP    = 15'd14;
   localparam logic [PERIOD_W-1:0]   RST_STOP_PERIOD  = 24'd65535;
   localparam logic [FACTOR_W-1:0]   RST_SPEED_FACTOR = 8'd50;
   localparam logic [NUM_MOTORS-1:0] RST_DIR_POLARITY = 3'd1;

   typedef struct packed {
      logic load;
      logic limit;
      logic scale;
      logic div_init;
      logic div_step;
      logic update;
      logic tick;
      logic out_load;
   } ctl_cmd_type;

   typedef struct packed {
      logic sel_valid;
      logic div_last;
   } ctl_stat_type;

endpackage

[sv/stepper_ramp_step_generator_core.sv]
// top level of the three-motor stepper step generator
// depends on srsg_pkg, srsg_ctrl and srsg_dpath
//
// req channel (valid/ready) carries one word: command, motor, target_speed.
// a set-speed word ramps the motor's speed toward the target by at most the
// acceleration cap, scales it by speed_factor and sets the step period to
// TICK_RATE / |scaled speed|, clamped to the stop period and at least 1.
// a tick word advances every motor's period counter; a moving motor whose
// counter reaches its period issues one step pulse and moves its position.
// rsp channel (valid/ready) returns one word per request word: pulses, pins
// and the selected motor's speed, period, direction and position.
// csr port: csr_we writes csr_wdata to register csr_index; write it only while idle (the block does not enforce this).
// set speed: the word passes the limit, scale, divide, update and respond
// states in that order; the period divider yields one quotient bit per cycle.
// tick or out-of-range motor: the word passes the tick or limit state, then respond.
// one word in flight; req_ready returns as the result loads, so a new word is
// taken only once the result of the last one has loaded.
// reset clears motor state (periods go to the default stop period), restores register defaults, drops rsp_valid.
// a stalled receiver holds the result; the next word is still accepted and
// its result waits in the sequencer until the output register frees up.

module stepper_ramp_step_generator_core #(
   parameter int TICK_RATE = 2000000
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // request channel
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [srsg_pkg::CMD_W-1:0]             req_command,
   input  logic [srsg_pkg::MOTOR_W-1:0]           req_motor,
   input  logic signed [srsg_pkg::SPEED_W-1:0]    req_target_speed,
   // response channel
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [srsg_pkg::NUM_MOTORS-1:0]        rsp_step_pulses,
   output logic [srsg_pkg::NUM_MOTORS-1:0]        rsp_dir_pins,
   output logic signed [srsg_pkg::SPEED_W-1:0]    rsp_speed_now,
   output logic [srsg_pkg::PERIOD_W-1:0]          rsp_step_period,
   output logic [srsg_pkg::DIR_W-1:0]             rsp_direction_code,
   output logic signed [srsg_pkg::POS_W-1:0]      rsp_position,
   // register write port
   input  logic                                   csr_we,
   input  logic [srsg_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [srsg_pkg::CSR_DATA_W-1:0]        csr_wdata
);
   import srsg_pkg::*;

   // command and status between sequencer and datapath
   ctl_cmd_type  cmd;
   ctl_stat_type stat;

   // sequencer: handshake, state walk, output valid
   srsg_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_command (req_command),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .stat        (stat),
      .cmd         (cmd)
   );

   // datapath: registers, motor state, arithmetic, output payload
   srsg_dpath #(
      .TICK_RATE (TICK_RATE)
   ) u_dpath (
      .clock              (clock),
      .reset              (reset),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_motor          (req_motor),
      .req_target_speed   (req_target_speed),
      .cmd                (cmd),
      .stat               (stat),
      .rsp_step_pulses    (rsp_step_pulses),
      .rsp_dir_pins       (rsp_dir_pins),
      .rsp_speed_now      (rsp_speed_now),
      .rsp_step_period    (rsp_step_period),
      .rsp_direction_code (rsp_direction_code),
      .rsp_position       (rsp_position)
   );

endmodule

[sv/srsg_ctrl.sv]
// sequencing state machine of the step generator
// depends on srsg_pkg and the assertion macro header
`include "stepper_ramp_step_generator_core_defines.svh"

module srsg_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [srsg_pkg::CMD_W-1:0]  req_command,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   input  srsg_pkg::ctl_stat_type      stat,
   output srsg_pkg::ctl_cmd_type       cmd
);
   import srsg_pkg::*;

   typedef enum logic [6:0] {
      ST_IDLE    = 7'b0000001,
      ST_LIMIT   = 7'b0000010,
      ST_SCALE   = 7'b0000100,
      ST_DIVIDE  = 7'b0001000,
      ST_UPDATE  = 7'b0010000,
      ST_TICK    = 7'b0100000,
      ST_RESPOND = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.load = 1'b1;
               state_in = (req_command == CMD_TICK) ? ST_TICK : ST_LIMIT;
            end
         end
         ST_LIMIT: begin
            if (stat.sel_valid) begin
               cmd.limit = 1'b1;
               state_in  = ST_SCALE;
            end else begin
               state_in  = ST_RESPOND;
            end
         end
         ST_SCALE: begin
            cmd.scale    = 1'b1;
            cmd.div_init = 1'b1;
            state_in     = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (stat.div_last) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = ST_RESPOND;
         end
         ST_TICK: begin
            cmd.tick = 1'b1;
            state_in = ST_RESPOND;
         end
         ST_RESPOND: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // one word in flight at a time
   `SRSG_ASSERT_NXT(a_single_item, clock, reset, accept, !req_ready)
   // tick words skip the divider path
   `SRSG_ASSERT_NXT(a_tick_path, clock, reset,
      accept && (req_command == CMD_TICK), state_ff == ST_TICK)
   // a finished result waits while the output stage is stalled
   `SRSG_ASSERT_NXT(a_respond_hold, clock, reset,
      (state_ff == ST_RESPOND) && rsp_valid_ff && !rsp_ready, state_ff == ST_RESPOND)

endmodule

[sv/srsg_dpath.sv]
// datapath of the step generator: registers, per-motor state, ramp limit,
// scaling multiply, iterative period divider and output stage; uses srsg_pkg
`include "stepper_ramp_step_generator_core_defines.svh"

module srsg_dpath #(
   parameter int TICK_RATE = 2000000
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_we,
   input  logic [srsg_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [srsg_pkg::CSR_DATA_W-1:0]        csr_wdata,
   input  logic [srsg_pkg::MOTOR_W-1:0]           req_motor,
   input  logic signed [srsg_pkg::SPEED_W-1:0]    req_target_speed,
   input  srsg_pkg::ctl_cmd_type                  cmd,
   output srsg_pkg::ctl_stat_type                 stat,
   output logic [srsg_pkg::NUM_MOTORS-1:0]        rsp_step_pulses,
   output logic [srsg_pkg::NUM_MOTORS-1:0]        rsp_dir_pins,
   output logic signed [srsg_pkg::SPEED_W-1:0]    rsp_speed_now,
   output logic [srsg_pkg::PERIOD_W-1:0]          rsp_step_period,
   output logic [srsg_pkg::DIR_W-1:0]             rsp_direction_code,
   output logic signed [srsg_pkg::POS_W-1:0]      rsp_position
);
   import srsg_pkg::*;

   localparam int DIV_W = $clog2(TICK_RATE + 1);
   localparam int CNT_W = $clog2(DIV_W);
   localparam logic [DIV_W-1:0] DIVIDEND = DIV_W'(TICK_RATE);
   localparam int PROD_W = SPEED_W + FACTOR_W + 1;

   // registers
   logic [ACCEL_W-1:0]    accel_cap_ff, accel_cap_in;
   logic [PERIOD_W-1:0]   stop_period_ff, stop_period_in;
   logic [FACTOR_W-1:0]   factor_ff, factor_in;
   logic [NUM_MOTORS-1:0] polarity_ff, polarity_in;

   // per-motor state
   logic signed [SPEED_W-1:0] speed_ff [NUM_MOTORS];
   logic signed [SPEED_W-1:0] speed_in [NUM_MOTORS];
   logic [DIR_W-1:0]    mdir_ff   [NUM_MOTORS];
   logic [DIR_W-1:0]    mdir_in   [NUM_MOTORS];
   logic [PERIOD_W-1:0] period_ff [NUM_MOTORS];
   logic [PERIOD_W-1:0] period_in [NUM_MOTORS];
   logic [PERIOD_W-1:0] tcount_ff [NUM_MOTORS];
   logic [PERIOD_W-1:0] tcount_in [NUM_MOTORS];
   logic [POS_W-1:0]    pos_ff    [NUM_MOTORS];
   logic [POS_W-1:0]    pos_in    [NUM_MOTORS];
   logic [NUM_MOTORS-1:0] dlvl_ff, dlvl_in;
   logic [NUM_MOTORS-1:0] pulses_ff, pulses_in;

   // working registers
   logic [MOTOR_W-1:0]        sel_ff;
   logic signed [SPEED_W-1:0] tgt_ff;
   logic signed [SPEED_W-1:0] nspd_ff, nspd_in;
   logic [PERIOD_W-1:0]       mag_ff, mag_in;
   logic                      neg_ff, neg_in;
   logic                      zero_ff, zero_in;
   logic [PERIOD_W-1:0]       rem_ff, rem_in;
   logic [DIV_W-1:0]          quot_ff, quot_in;
   logic [CNT_W-1:0]          cnt_ff, cnt_in;

   // output stage
   logic [NUM_MOTORS-1:0]     o_pulses_ff;
   logic [NUM_MOTORS-1:0]     o_pins_ff;
   logic signed [SPEED_W-1:0] o_speed_ff;
   logic [PERIOD_W-1:0]       o_period_ff;
   logic [DIR_W-1:0]          o_dir_ff;
   logic [POS_W-1:0]          o_pos_ff;

   logic sel_valid;
   assign sel_valid     = ({1'b0, sel_ff} < (MOTOR_W + 1)'(NUM_MOTORS));
   assign stat.sel_valid = sel_valid;
   assign stat.div_last  = (cnt_ff == '0);

   // register writes
   always_comb begin
      accel_cap_in   = accel_cap_ff;
      stop_period_in = stop_period_ff;
      factor_in      = factor_ff;
      polarity_in    = polarity_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_ACCEL_CAP:    accel_cap_in   = csr_wdata[ACCEL_W-1:0];
            CSR_STOP_PERIOD:  stop_period_in = csr_wdata[PERIOD_W-1:0];
            CSR_SPEED_FACTOR: factor_in      = csr_wdata[FACTOR_W-1:0];
            CSR_DIR_POLARITY: polarity_in    = csr_wdata[NUM_MOTORS-1:0];
            default:          accel_cap_in   = accel_cap_ff;
         endcase
      end
   end

   // ramp limit: move toward target by at most the acceleration cap
   logic signed [SPEED_W:0] cur_x, tgt_x, acc_x, diff;
   always_comb begin
      cur_x = $signed({speed_ff[sel_ff][SPEED_W-1], speed_ff[sel_ff]});
      tgt_x = $signed({tgt_ff[SPEED_W-1], tgt_ff});
      acc_x = $signed({2'b00, accel_cap_ff});
      diff  = cur_x - tgt_x;
      if (diff > acc_x) begin
         nspd_in = SPEED_W'(cur_x - acc_x);
      end else if (diff < -acc_x) begin
         nspd_in = SPEED_W'(cur_x + acc_x);
      end else begin
         nspd_in = tgt_ff;
      end
   end

   // scaling multiply, full width
   logic signed [PROD_W-1:0] prod, prod_abs;
   always_comb begin
      prod     = nspd_ff * $signed({1'b0, factor_ff});
      prod_abs = prod[PROD_W-1] ? -prod : prod;
      mag_in   = prod_abs[PERIOD_W-1:0];
      neg_in   = prod[PROD_W-1];
      zero_in  = (prod == '0);
   end

   // restoring divider, one quotient bit per cycle
   logic [PERIOD_W:0] trial;
   logic              ge;
   always_comb begin
      trial   = {rem_ff, DIVIDEND[cnt_ff]};
      ge      = (trial >= {1'b0, mag_ff});
      rem_in  = rem_ff;
      quot_in = quot_ff;
      cnt_in  = cnt_ff;
      if (cmd.div_init) begin
         rem_in  = '0;
         quot_in = '0;
         cnt_in  = CNT_W'(DIV_W - 1);
      end else if (cmd.div_step) begin
         rem_in  = ge ? PERIOD_W'(trial - {1'b0, mag_ff}) : trial[PERIOD_W-1:0];
         quot_in = {quot_ff[DIV_W-2:0], ge};
         cnt_in  = cnt_ff - 1'b1;
      end
   end

   // period clamp
   logic [PERIOD_W-1:0] q_ext, per_clamp, per_final;
   always_comb begin
      q_ext = PERIOD_W'(quot_ff);
      if (zero_ff) begin
         per_clamp = stop_period_ff;
      end else if (q_ext > stop_period_ff) begin
         per_clamp = stop_period_ff;
      end else begin
         per_clamp = q_ext;
      end
      per_final = (per_clamp == '0) ? PERIOD_W'(1) : per_clamp;
   end

   // per-motor state update
   logic [PERIOD_W:0] cnext [NUM_MOTORS];
   always_comb begin
      speed_in  = speed_ff;
      mdir_in   = mdir_ff;
      period_in = period_ff;
      tcount_in = tcount_ff;
      pos_in    = pos_ff;
      dlvl_in   = dlvl_ff;
      pulses_in = pulses_ff;
      for (int m = 0; m < NUM_MOTORS; m++) begin
         cnext[m] = {1'b0, tcount_ff[m]} + 1'b1;
      end
      if (cmd.load) begin
         pulses_in = '0;
      end
      if (cmd.update) begin
         speed_in[sel_ff]  = nspd_ff;
         period_in[sel_ff] = per_final;
         if (zero_ff) begin
            mdir_in[sel_ff] = DIR_STOP;
         end else if (neg_ff) begin
            mdir_in[sel_ff] = DIR_REV;
            dlvl_in[sel_ff] = ~polarity_ff[sel_ff];
         end else begin
            mdir_in[sel_ff] = DIR_FWD;
            dlvl_in[sel_ff] = polarity_ff[sel_ff];
         end
      end
      if (cmd.tick) begin
         for (int m = 0; m < NUM_MOTORS; m++) begin
            if (cnext[m] >= {1'b0, period_ff[m]}) begin
               tcount_in[m] = '0;
               if (mdir_ff[m] == DIR_FWD) begin
                  pos_in[m]    = pos_ff[m] - 1'b1;
                  pulses_in[m] = 1'b1;
               end else if (mdir_ff[m] == DIR_REV) begin
                  pos_in[m]    = pos_ff[m] + 1'b1;
                  pulses_in[m] = 1'b1;
               end
            end else begin
               tcount_in[m] = cnext[m][PERIOD_W-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         accel_cap_ff   <= RST_ACCEL_CAP;
         stop_period_ff <= RST_STOP_PERIOD;
         factor_ff      <= RST_SPEED_FACTOR;
         polarity_ff    <= RST_DIR_POLARITY;
         for (int m = 0; m < NUM_MOTORS; m++) begin
            speed_ff[m]  <= '0;
            mdir_ff[m]   <= DIR_STOP;
            period_ff[m] <= RST_STOP_PERIOD;
            tcount_ff[m] <= '0;
            pos_ff[m]    <= '0;
         end
         dlvl_ff   <= '0;
         pulses_ff <= '0;
      end else begin
         accel_cap_ff   <= accel_cap_in;
         stop_period_ff <= stop_period_in;
         factor_ff      <= factor_in;
         polarity_ff    <= polarity_in;
         speed_ff       <= speed_in;
         mdir_ff        <= mdir_in;
         period_ff      <= period_in;
         tcount_ff      <= tcount_in;
         pos_ff         <= pos_in;
         dlvl_ff        <= dlvl_in;
         pulses_ff      <= pulses_in;
      end
   end

   // working and output registers, no reset needed
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         sel_ff <= req_motor;
         tgt_ff <= req_target_speed;
      end
      if (cmd.limit) begin
         nspd_ff <= nspd_in;
      end
      if (cmd.scale) begin
         mag_ff  <= mag_in;
         neg_ff  <= neg_in;
         zero_ff <= zero_in;
      end
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
      cnt_ff  <= cnt_in;
      if (cmd.out_load) begin
         o_pulses_ff <= pulses_ff;
         o_pins_ff   <= dlvl_ff;
         if (sel_valid) begin
            o_speed_ff  <= speed_ff[sel_ff];
            o_period_ff <= period_ff[sel_ff];
            o_dir_ff    <= mdir_ff[sel_ff];
            o_pos_ff    <= pos_ff[sel_ff];
         end else begin
            o_speed_ff  <= '0;
            o_period_ff <= '0;
            o_dir_ff    <= DIR_STOP;
            o_pos_ff    <= '0;
         end
      end
   end

   assign rsp_step_pulses    = o_pulses_ff;
   assign rsp_dir_pins       = o_pins_ff;
   assign rsp_speed_now      = o_speed_ff;
   assign rsp_step_period    = o_period_ff;
   assign rsp_direction_code = o_dir_ff;
   assign rsp_position       = $signed(o_pos_ff);

   // a written period is never zero
   `SRSG_ASSERT_NXT(a_period_nonzero, clock, reset, cmd.update, period_ff[sel_ff] != '0)
   // after a tick motor 0's counter sits below its period
   `SRSG_ASSERT_NXT(a_count_below_period, clock, reset, cmd.tick,
      tcount_ff[0] < period_ff[0])
   // motor 0 never pulses while stopped
   `SRSG_ASSERT_IMP(a_pulse_needs_motion, clock, reset, pulses_ff[0],
      mdir_ff[0] != DIR_STOP)

endmodule

[sim/srsg_step_checker.sv]
// response checker for the three-motor stepper step generator
// watches the request, response and register ports; predicts and compares
// depends on srsg_pkg only
module srsg_step_checker #(
   parameter int TICK_RATE = 2000000
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_ready,
   input  logic [srsg_pkg::CMD_W-1:0]          req_command,
   input  logic [srsg_pkg::MOTOR_W-1:0]        req_motor,
   input  logic signed [srsg_pkg::SPEED_W-1:0] req_target_speed,
   input  logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  logic [srsg_pkg::NUM_MOTORS-1:0]     rsp_step_pulses,
   input  logic [srsg_pkg::NUM_MOTORS-1:0]     rsp_dir_pins,
   input  logic signed [srsg_pkg::SPEED_W-1:0] rsp_speed_now,
   input  logic [srsg_pkg::PERIOD_W-1:0]       rsp_step_period,
   input  logic [srsg_pkg::DIR_W-1:0]          rsp_direction_code,
   input  logic signed [srsg_pkg::POS_W-1:0]   rsp_position,
   input  logic                                csr_we,
   input  logic [srsg_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [srsg_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output int                                  mismatches,
   output int                                  outstanding,
   output int                                  pulses_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   import srsg_pkg::*;

   typedef struct packed {
      logic [NUM_MOTORS-1:0]     pulses;
      logic [NUM_MOTORS-1:0]     pins;
      logic signed [SPEED_W-1:0] speed;
      logic [PERIOD_W-1:0]       period;
      logic [DIR_W-1:0]          dir;
      logic signed [POS_W-1:0]   pos;
   } motor_report_type;

   // register copies
   logic [ACCEL_W-1:0]    accel_lim;
   logic [PERIOD_W-1:0]   slow_period;
   logic [FACTOR_W-1:0]   scale;
   logic [NUM_MOTORS-1:0] polarity;

   // per-motor state
   logic signed [SPEED_W-1:0] motor_speed  [NUM_MOTORS];
   logic [DIR_W-1:0]          motor_dir    [NUM_MOTORS];
   logic [PERIOD_W-1:0]       motor_period [NUM_MOTORS];
   logic [PERIOD_W-1:0]       motor_count  [NUM_MOTORS];
   logic [POS_W-1:0]          motor_pos    [NUM_MOTORS];
   logic [NUM_MOTORS-1:0]     pin_levels;

   motor_report_type expected_reports[$];
   int errors = 0;
   int pulse_total = 0;

   function automatic motor_report_type predict_report(input logic [CMD_W-1:0] cmd,
         input logic [MOTOR_W-1:0] sel, input logic signed [SPEED_W-1:0] target);
      motor_report_type rep;
      int speed, gap, accel, scaled, mag, per;
      logic [PERIOD_W:0] next_count;
      rep = '0;
      if (cmd == CMD_SET_SPEED) begin
         if (sel < NUM_MOTORS) begin
            // ramp toward the target, at most accel_lim per word
            speed = motor_speed[sel];
            accel = int'(accel_lim);
            gap = speed - target;
            if (gap > accel)
               speed -= accel;
            else if (gap < -accel)
               speed += accel;
            else
               speed = target;
            motor_speed[sel] = speed[SPEED_W-1:0];
            // full-width product, no 16-bit wrap
            scaled = speed * int'(scale);
            if (scaled == 0) begin
               per = int'(slow_period);
               motor_dir[sel] = DIR_STOP;
            end else begin
               if (scaled > 0) begin
                  mag = scaled;
                  motor_dir[sel] = DIR_FWD;
                  pin_levels[sel] = polarity[sel];
               end else begin
                  mag = -scaled;
                  motor_dir[sel] = DIR_REV;
                  pin_levels[sel] = ~polarity[sel];
               end
               per = TICK_RATE / mag;
               if (per > int'(slow_period))
                  per = int'(slow_period);
            end
            if (per == 0)
               per = 1;
            motor_period[sel] = per[PERIOD_W-1:0];
         end
      end else begin
         for (int m = 0; m < NUM_MOTORS; m++) begin
            next_count = {1'b0, motor_count[m]} + 1'b1;
            if (next_count >= {1'b0, motor_period[m]}) begin
               next_count = '0;
               if (motor_dir[m] == DIR_FWD) begin
                  motor_pos[m] -= 1;
                  rep.pulses[m] = 1'b1;
               end else if (motor_dir[m] == DIR_REV) begin
                  motor_pos[m] += 1;
                  rep.pulses[m] = 1'b1;
               end
            end
            motor_count[m] = next_count[PERIOD_W-1:0];
         end
      end
      rep.pins = pin_levels;
      if (sel < NUM_MOTORS) begin
         rep.speed  = motor_speed[sel];
         rep.period = motor_period[sel];
         rep.dir    = motor_dir[sel];
         rep.pos    = motor_pos[sel];
      end
      return rep;
   endfunction

   function automatic void check_field(input string label,
         input logic signed [63:0] want, input logic signed [63:0] got);
      if (want !== got) begin
         $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
         errors++;
      end
   endfunction

   always @(posedge clock) begin : watch
      motor_report_type want;
      if (reset) begin
         accel_lim   = RST_ACCEL_CAP;
         slow_period = RST_STOP_PERIOD;
         scale       = RST_SPEED_FACTOR;
         polarity    = RST_DIR_POLARITY;
         pin_levels  = '0;
         for (int m = 0; m < NUM_MOTORS; m++) begin
            motor_speed[m]  = '0;
            motor_dir[m]    = DIR_STOP;
            motor_period[m] = RST_STOP_PERIOD;
            motor_count[m]  = '0;
            motor_pos[m]    = '0;
         end
         expected_reports.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_ACCEL_CAP:    accel_lim   = csr_wdata[ACCEL_W-1:0];
               CSR_STOP_PERIOD:  slow_period = csr_wdata[PERIOD_W-1:0];
               CSR_SPEED_FACTOR: scale       = csr_wdata[FACTOR_W-1:0];
               CSR_DIR_POLARITY: polarity    = csr_wdata[NUM_MOTORS-1:0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_reports.size() == 0) begin
               $display("%0t ns: unexpected word, pulses %b pins %b speed %0d",
                        $time, rsp_step_pulses, rsp_dir_pins, rsp_speed_now);
               $display("%0t ns: unexpected word, period %0d dir %0d pos %0d",
                        $time, rsp_step_period, rsp_direction_code, rsp_position);
               errors++;
            end else begin
               want = expected_reports.pop_front();
               pulse_total += $countones(want.pulses);
               check_field("step_pulses", 64'(want.pulses), 64'(rsp_step_pulses));
               check_field("dir_pins", 64'(want.pins), 64'(rsp_dir_pins));
               check_field("speed_now", 64'(want.speed), 64'(rsp_speed_now));
               check_field("step_period", 64'(want.period), 64'(rsp_step_period));
               check_field("direction_code", 64'(want.dir), 64'(rsp_direction_code));
               check_field("position", 64'(want.pos), 64'(rsp_position));
            end
         end
         if (req_valid && req_ready)
            expected_reports.push_back(predict_report(req_command, req_motor, req_target_speed));
      end
      mismatches  <= errors;
      outstanding <= expected_reports.size();
      pulses_seen <= pulse_total;
   end

endmodule

[sim/testbench.sv]
// top of the stepper step generator testbench: clock, reset, stimulus, verdict
// depends on srsg_pkg, srsg_step_checker and the block under test
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import srsg_pkg::*;

   localparam int TICK_RATE       = 2000000;
   localparam int NUM_PHASES      = 8;
   localparam int ITEMS_PER_PHASE = 100;
   localparam int LONG_HOLD       = 400;      // receiver hold-off that backs up the block
   localparam int DRAIN_CYCLES    = 40;       // longer than the set-speed divide latency
   localparam int CYCLE_LIMIT     = 400000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic [CMD_W-1:0]          req_command = CMD_TICK;
   logic [MOTOR_W-1:0]        req_motor = '0;
   logic signed [SPEED_W-1:0] req_target_speed = '0;

   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic [NUM_MOTORS-1:0]     rsp_step_pulses;
   logic [NUM_MOTORS-1:0]     rsp_dir_pins;
   logic signed [SPEED_W-1:0] rsp_speed_now;
   logic [PERIOD_W-1:0]       rsp_step_period;
   logic [DIR_W-1:0]          rsp_direction_code;
   logic signed [POS_W-1:0]   rsp_position;

   logic                      csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]      csr_index = '0;
   logic [CSR_DATA_W-1:0]     csr_wdata = '0;

   int mismatches, outstanding, pulses_seen;

   // shared pacing controls: calm turns off idling on both sides,
   // hold_requests asks the receiver for one long hold-off
   logic calm = 1'b0;
   int   hold_requests = 0;
   int   set_words = 0;
   int   tick_words = 0;
   int unsigned cycle_count = 0;

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   stepper_ramp_step_generator_core #(.TICK_RATE(TICK_RATE)) uut (.*);

   srsg_step_checker #(.TICK_RATE(TICK_RATE)) u_check (.*);

   // idle length: mostly none, some short, a few long
   function automatic int idle_cycles();
      int r;
      r = $urandom_range(0, 99);
      if (calm)
         return 0;
      if (r < 55)
         return 0;
      if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // offer one request word and wait for its handshake;
   // valid is only lowered when a gap comes first
   task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [MOTOR_W-1:0] motor,
         input logic signed [SPEED_W-1:0] target);
      int gap;
      gap = idle_cycles();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_command      <= cmd;
      req_motor        <= motor;
      req_target_speed <= target;
      do @(posedge clock); while (!req_ready);
      if (cmd == CMD_SET_SPEED)
         set_words++;
      else
         tick_words++;
   endtask

   // stop offering and wait until every expected word is back
   task automatic quiesce();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   // one register write; the caller drops the write enable afterwards
   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   task automatic program_regs(input logic [ACCEL_W-1:0] accel, input logic [PERIOD_W-1:0] zs,
         input logic [FACTOR_W-1:0] factor, input logic [NUM_MOTORS-1:0] pol);
      csr_write(CSR_ACCEL_CAP, CSR_DATA_W'(accel));
      csr_write(CSR_STOP_PERIOD, zs);
      csr_write(CSR_SPEED_FACTOR, CSR_DATA_W'(factor));
      csr_write(CSR_DIR_POLARITY, CSR_DATA_W'(pol));
      csr_we <= 1'b0;
   endtask

   // receiver: random ready pattern, plus the requested long hold-offs
   initial begin : receiver
      int holds_done;
      holds_done = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (holds_done != hold_requests) begin
            holds_done++;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else if (calm) begin
            rsp_ready <= 1'b1;
            @(posedge clock);
         end else if ($urandom_range(0, 99) < 50) begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b0;
            repeat (idle_cycles() + 1) @(posedge clock);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t ns: timeout after %0d cycles, %0d words still expected",
                  $time, cycle_count, outstanding);
         $display("testbench: FAIL");
         $finish;
      end
   end

   initial begin : stimulus
      int phase, i, kind;
      logic [MOTOR_W-1:0]        sel;
      logic signed [SPEED_W-1:0] speed;
      logic [ACCEL_W-1:0]        accel;
      logic [PERIOD_W-1:0]       zs;
      logic [FACTOR_W-1:0]       factor;
      logic [NUM_MOTORS-1:0]     pol;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed, reset register values: small ramps, out-of-range motor, stop
      send_word(CMD_TICK, 2'd0, 16'sd0);          // everything stopped, no pulse
      send_word(CMD_SET_SPEED, 2'd0, 16'sd32767); // ramps by the acceleration cap only
      send_word(CMD_SET_SPEED, 2'd1, -16'sd32768);// reverse, inverted pin
      send_word(CMD_SET_SPEED, 2'd2, 16'sd0);     // stays stopped
      send_word(CMD_SET_SPEED, 2'd3, 16'sd1234);  // no such motor: no change, zero fields
      send_word(CMD_TICK, 2'd3, -16'sd1);
      send_word(CMD_SET_SPEED, 2'd0, -16'sd5);    // clipped to zero: stop, pin kept
      send_word(CMD_SET_SPEED, 2'd0, -16'sd5);    // now reaches the target
      send_word(CMD_SET_SPEED, 2'd2, 16'sd7);     // within the step limit
      send_word(CMD_TICK, 2'd1, 16'sd0);

      // fast ramps at the largest factor: periods collapse to one tick
      quiesce();
      program_regs(15'd32767, 24'd16777215, 8'd255, 3'd7);
      send_word(CMD_SET_SPEED, 2'd0, 16'sd32767);
      send_word(CMD_SET_SPEED, 2'd1, -16'sd32768);
      send_word(CMD_TICK, 2'd0, 16'sd0);
      send_word(CMD_TICK, 2'd1, 16'sd0);
      send_word(CMD_SET_SPEED, 2'd2, 16'sd1);     // long period, below the stop period
      send_word(CMD_SET_SPEED, 2'd0, 16'sd0);
      send_word(CMD_TICK, 2'd2, 16'sd0);

      // a new stop period only applies at the motor's next set-speed word;
      // the counter is not cleared so motor 2 fires on the next tick
      quiesce();
      program_regs(15'd32767, 24'd1, 8'd255, 3'd7);
      send_word(CMD_TICK, 2'd2, 16'sd0);
      send_word(CMD_SET_SPEED, 2'd2, 16'sd1);
      send_word(CMD_TICK, 2'd2, 16'sd0);

      // random phases, each with its own register setting
      for (phase = 0; phase < NUM_PHASES; phase++) begin
         quiesce();
         case (phase)
            0: begin accel = 15'd32767; zs = 24'd16777215; factor = 8'd255; pol = 3'd7; end
            1: begin accel = 15'd0;     zs = 24'd1;        factor = 8'd1;   pol = 3'd0; end
            2: begin accel = 15'd2000;  zs = 24'd200;      factor = 8'd25;  pol = 3'd5; end
            3: begin accel = 15'd300;   zs = 24'd64;       factor = 8'd50;  pol = 3'd2; end
            default: begin
               accel  = ACCEL_W'($urandom_range(0, 1) ? $urandom_range(0, 32767)
                                                      : $urandom_range(0, 600));
               zs     = PERIOD_W'($urandom_range(0, 1) ? $urandom_range(1, 400)
                                                       : $urandom_range(1, 16777215));
               factor = FACTOR_W'($urandom_range(1, 255));
               pol    = NUM_MOTORS'($urandom_range(0, 7));
            end
         endcase
         program_regs(accel, zs, factor, pol);
         // even phases open with a stretch of back-to-back words
         calm <= (phase % 2 == 0);

         for (i = 0; i < ITEMS_PER_PHASE; i++) begin
            if (i == 30)
               calm <= 1'b0;
            // receiver stops long enough for the block to back up its input
            if (phase == 3 && i == 50)
               hold_requests <= hold_requests + 1;
            // sender waits for a fully drained block mid-phase
            if (phase == 5 && i == 60)
               quiesce();

            kind = $urandom_range(0, 99);
            if ($urandom_range(0, 19) == 0)
               sel = 2'd3;
            else
               sel = MOTOR_W'($urandom_range(0, 2));
            case ($urandom_range(0, 9))
               0, 1, 2, 3: speed = SPEED_W'($urandom_range(0, 65535));
               4, 5, 6:    speed = SPEED_W'($urandom_range(0, 600) - 300);
               7:          speed = 16'sd0;
               8:          speed = $urandom_range(0, 1) ? 16'sd32767 : -16'sd32768;
               default:    speed = SPEED_W'($urandom_range(0, 2) - 1);
            endcase
            // ticks dominate so that counters actually wrap and steps appear
            if (kind < 62)
               send_word(CMD_TICK, sel, speed);
            else
               send_word(CMD_SET_SPEED, sel, speed);
         end
      end

      quiesce();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("summary: %0d set-speed and %0d tick words over %0d register settings",
               set_words, tick_words, NUM_PHASES + 3);
      $display("summary: %0d step pulses checked, %0d mismatches", pulses_seen, mismatches);
      if (mismatches == 0)
         $display("testbench: PASS");
      else
         $display("testbench: FAIL");
      $finish;
   end

endmodule
